### rtl/core/char_plot_rasterizer_defines.svh
// -----------------------------------------------------------------------------
// char_plot_rasterizer_defines
// Assertion shorthands shared by the rasterizer RTL.
// -----------------------------------------------------------------------------
`ifndef CHAR_PLOT_RASTERIZER_DEFINES_SVH
`define CHAR_PLOT_RASTERIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CRP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/crp_pkg.sv
// -----------------------------------------------------------------------------
// crp_pkg
// Types, codes and constants of the character plot rasterizer.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crp_pkg;

  localparam int unsigned CELL_COUNT_DEF = 8192;
  localparam int unsigned NUM_CURVES_DEF = 8;
  localparam int unsigned MAX_PAGE_CHARS = 10000;

  localparam int unsigned Q_W   = 8;   // quotient bits: row/col never exceed 254
  localparam int unsigned DEN_W = 33;  // twice a 32-bit span
  localparam int unsigned NUM_W = 42;  // 2*scale*offset + span
  localparam int unsigned IDX_W = 17;

  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_A     = 8'h41;
  localparam logic [7:0] CHR_ONE   = 8'h31;
  localparam logic [7:0] CHR_TWO   = 8'h32;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_STAR  = 8'h2A;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_BOUND = 2'd1,
    REQ_PLOT  = 2'd2,
    REQ_READ  = 2'd3
  } crp_req_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_TOO_BIG  = 2'd1,
    STS_NO_DATA  = 2'd2,
    STS_BAD_CELL = 2'd3
  } crp_status_e;

  typedef enum logic [2:0] {
    REG_PAGE_WIDTH  = 3'd0,
    REG_PAGE_LENGTH = 3'd1,
    REG_LIMIT_MASK  = 3'd2,
    REG_X_LOW       = 3'd3,
    REG_X_HIGH      = 3'd4,
    REG_Y_LOW       = 3'd5,
    REG_Y_HIGH      = 3'd6
  } crp_reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COL_MUL,
    ST_COL_DIV,
    ST_ROW_MUL,
    ST_ROW_DIV,
    ST_INDEX,
    ST_MEM_RD,
    ST_MEM_USE,
    ST_DONE
  } crp_state_e;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quot;
  } crp_div_rsp_t;

endpackage

### rtl/core/crp_div.sv
// -----------------------------------------------------------------------------
// crp_div
// Restoring divider, one quotient bit per cycle, for an 8-bit quotient.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crp_div
  import crp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output crp_div_rsp_t     rsp_o
);

  localparam int unsigned CNT_W = $clog2(Q_W);

  logic [NUM_W-1:0] rem_q, rem_d, den_q, den_d;
  logic [Q_W-1:0]   quot_q, quot_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic             fits;

  assign fits = (rem_q >= den_q);

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num_i;
      den_d  = NUM_W'(den_i) << (Q_W - 1);
      quot_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? rem_q - den_q : rem_q;
      quot_d = {quot_q[Q_W-2:0], fits};
      den_d  = den_q >> 1;
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(Q_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

### rtl/core/char_plot_rasterizer.sv
// -----------------------------------------------------------------------------
// char_plot_rasterizer
// Scatter points to a character grid in Q16.16, one request at a time.
// -----------------------------------------------------------------------------
// Usage: requests enter on the s_axis channel (tuser = request type), one
// result per request leaves on m_axis. The APB port sets page size, limit
// mask and fixed limits; write it only while the block is idle.
// Steps: a bound point goes straight to the result; a read forms the cell
// index and reads the cell; a plot in bounds runs column, then row, through
// one multiplier and an 8-step division on one shared restoring divider,
// then forms the index on a second multiplier and updates the cell. A start
// that fits sweeps the grid store one cell per cycle. Reset: the block
// sweeps the grid to spaces and holds s_axis_tready low meanwhile; APB
// writes are taken throughout. Stall: the result waits in the output
// register; one more request may be taken and worked on, and its result
// holds until m_axis_tready frees the register.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "char_plot_rasterizer_defines.svh"

module char_plot_rasterizer
  import crp_pkg::*;
#(
  parameter int unsigned CELL_COUNT = CELL_COUNT_DEF,
  parameter int unsigned NUM_CURVES = NUM_CURVES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // APB configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // request channel
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [2:0] curve_index, [34:3] x_coord, [66:35] y_coord,
  // [73:67] cell_row, [80:74] cell_col, [87:81] zero
  input  logic [87:0]  s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]   s_axis_tuser,
  // result channel
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [1:0] status, [9:2] cell_char, [25:10] point_count, [57:26] bound_x_low,
  // [89:58] bound_x_high, [121:90] bound_y_low, [153:122] bound_y_high,
  // [159:154] zero
  output logic [159:0] m_axis_tdata
);

  localparam int unsigned AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0]         pw_q, pl_q;
  logic [3:0]         mask_q;
  logic signed [31:0] xlo_lim_q, xhi_lim_q, ylo_lim_q, yhi_lim_q;
  logic               cfg_wr;
  crp_reg_e           cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = crp_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q      <= 8'd80;
      pl_q      <= 8'd24;
      mask_q    <= '0;
      xlo_lim_q <= '0;
      xhi_lim_q <= '0;
      ylo_lim_q <= '0;
      yhi_lim_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_PAGE_WIDTH:  pw_q      <= pwdata[7:0];
        REG_PAGE_LENGTH: pl_q      <= pwdata[7:0];
        REG_LIMIT_MASK:  mask_q    <= pwdata[3:0];
        REG_X_LOW:       xlo_lim_q <= pwdata;
        REG_X_HIGH:      xhi_lim_q <= pwdata;
        REG_Y_LOW:       ylo_lim_q <= pwdata;
        REG_Y_HIGH:      yhi_lim_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_PAGE_WIDTH:  prdata = 32'(pw_q);
      REG_PAGE_LENGTH: prdata = 32'(pl_q);
      REG_LIMIT_MASK:  prdata = 32'(mask_q);
      REG_X_LOW:       prdata = xlo_lim_q;
      REG_X_HIGH:      prdata = xhi_lim_q;
      REG_Y_LOW:       prdata = ylo_lim_q;
      REG_Y_HIGH:      prdata = yhi_lim_q;
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Request fields
  // ---------------------------------------------------------------------------
  crp_req_e           in_req;
  logic [2:0]         in_curve;
  logic signed [31:0] in_x, in_y;
  logic [6:0]         in_row, in_col;

  assign in_req   = crp_req_e'(s_axis_tuser);
  assign in_curve = s_axis_tdata[2:0];
  assign in_x     = s_axis_tdata[34:3];
  assign in_y     = s_axis_tdata[66:35];
  assign in_row   = s_axis_tdata[73:67];
  assign in_col   = s_axis_tdata[80:74];

  // Zero page size maps as one.
  logic [7:0] w_eff, l_eff;
  assign w_eff = (pw_q == '0) ? 8'd1 : pw_q;
  assign l_eff = (pl_q == '0) ? 8'd1 : pl_q;

  // ---------------------------------------------------------------------------
  // Sequencer state and working registers
  // ---------------------------------------------------------------------------
  crp_state_e         state_q, state_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic               clr_resp_q, clr_resp_d;
  logic signed [31:0] lox_q, lox_d, hix_q, hix_d, loy_q, loy_d, hiy_q, hiy_d;
  logic [15:0]        cnt_q, cnt_d;
  logic [1:0]         status_q, status_d;
  logic [7:0]         char_q, char_d;
  logic [2:0]         curve_q, curve_d;
  logic               is_read_q, is_read_d;
  logic               bad_rc_q, bad_rc_d;
  logic [31:0]        sx_q, sx_d, dx_q, dx_d, sy_q, sy_d, dy_q, dy_d;
  logic [7:0]         row_q, row_d, col_q, col_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               out_vld_q, out_vld_d;
  logic [159:0]       out_q, out_d;

  logic               accept;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Page and point checks on the incoming request
  logic [15:0] page_cells;
  logic        too_big, curve_ok, reject, in_bounds;
  assign page_cells = pw_q * pl_q;
  assign too_big    = (page_cells > 16'(MAX_PAGE_CHARS)) ||
                      (IDX_W'(page_cells) > IDX_W'(CELL_COUNT));
  assign curve_ok   = (5'(in_curve) < 5'(NUM_CURVES));
  assign reject     = !curve_ok ||
                      (mask_q[0] && in_x < lox_q) || (mask_q[1] && in_x > hix_q) ||
                      (mask_q[2] && in_y < loy_q) || (mask_q[3] && in_y > hiy_q);
  assign in_bounds  = (in_x >= lox_q) && (in_x <= hix_q) &&
                      (in_y >= loy_q) && (in_y <= hiy_q);

  // ---------------------------------------------------------------------------
  // Shared multiplier feeding the shared divider, and the index multiplier
  // ---------------------------------------------------------------------------
  logic         col_phase;
  logic [7:0]   mul_scale;
  logic [31:0]  mul_off, mul_span;
  logic [39:0]  mul_prod;
  logic [15:0]  idx_prod;
  logic         div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  crp_div_rsp_t div_rsp;

  assign col_phase = (state_q == ST_COL_MUL);
  assign mul_scale = col_phase ? w_eff - 8'd1 : l_eff - 8'd1;
  assign mul_off   = col_phase ? dx_q : dy_q;
  assign mul_span  = col_phase ? sx_q : sy_q;
  assign mul_prod  = mul_scale * mul_off;
  assign div_num   = NUM_W'({mul_prod, 1'b0}) + NUM_W'(mul_span);
  assign div_den   = {mul_span, 1'b0};
  assign div_start = (state_q == ST_COL_MUL) || (state_q == ST_ROW_MUL);
  assign idx_prod  = row_q * w_eff;

  crp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .rsp_o   (div_rsp)
  );

  // ---------------------------------------------------------------------------
  // Grid store
  // ---------------------------------------------------------------------------
  logic [7:0]    mem [CELL_COUNT];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata, rd_q, cell_next;
  logic          idx_ok;

  assign idx_ok = (idx_q < IDX_W'(CELL_COUNT));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[idx_q[AW-1:0]];
  end

  // Hit count: letter on an empty cell, then '2'..'9', then '*'
  always_comb begin
    if (rd_q == CHR_SPACE) begin
      cell_next = CHR_A + 8'(curve_q);
    end else if (rd_q > CHR_ONE && rd_q < CHR_NINE) begin
      cell_next = rd_q + 8'd1;
    end else if (rd_q == CHR_NINE || rd_q == CHR_STAR) begin
      cell_next = CHR_STAR;
    end else begin
      cell_next = CHR_TWO;
    end
  end

  // ---------------------------------------------------------------------------
  // Next state and datapath control
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    clr_resp_d = clr_resp_q;
    lox_d = lox_q; hix_d = hix_q; loy_d = loy_q; hiy_d = hiy_q;
    cnt_d      = cnt_q;
    status_d   = status_q;
    char_d     = char_q;
    curve_d    = curve_q;
    is_read_d  = is_read_q;
    bad_rc_d   = bad_rc_q;
    sx_d = sx_q; dx_d = dx_q; sy_d = sy_q; dy_d = dy_q;
    row_d      = row_q;
    col_d      = col_q;
    idx_d      = idx_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_d      = out_q;
    mem_we     = 1'b0;
    mem_waddr  = idx_q[AW-1:0];
    mem_wdata  = cell_next;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = CHR_SPACE;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(CELL_COUNT - 1)) begin
          clr_d   = '0;
          state_d = clr_resp_q ? ST_DONE : ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          status_d  = STS_OK;
          char_d    = '0;
          curve_d   = in_curve;
          is_read_d = 1'b0;
          state_d   = ST_DONE;
          case (in_req)
            REQ_START: begin
              if (too_big) begin
                status_d = STS_TOO_BIG;
              end else begin
                lox_d      = mask_q[0] ? xlo_lim_q : 32'sh7FFFFFFF;
                hix_d      = mask_q[1] ? xhi_lim_q : 32'sh80000000;
                loy_d      = mask_q[2] ? ylo_lim_q : 32'sh7FFFFFFF;
                hiy_d      = mask_q[3] ? yhi_lim_q : 32'sh80000000;
                cnt_d      = '0;
                clr_resp_d = 1'b1;
                state_d    = ST_CLEAR;
              end
            end
            REQ_BOUND: begin
              if (!reject) begin
                if (in_x < lox_q) lox_d = in_x;
                if (in_x > hix_q) hix_d = in_x;
                if (in_y < loy_q) loy_d = in_y;
                if (in_y > hiy_q) hiy_d = in_y;
                if (cnt_q != 16'hFFFF) cnt_d = cnt_q + 16'd1;
              end
            end
            REQ_PLOT: begin
              if (cnt_q == '0) begin
                status_d = STS_NO_DATA;
              end else if (curve_ok && in_bounds) begin
                sx_d    = hix_q - lox_q;
                dx_d    = in_x - lox_q;
                sy_d    = hiy_q - loy_q;
                dy_d    = hiy_q - in_y;   // flipped y offset
                state_d = ST_COL_MUL;
              end
            end
            default: begin  // read cell
              is_read_d = 1'b1;
              row_d     = 8'(in_row);
              col_d     = 8'(in_col);
              bad_rc_d  = (8'(in_row) >= l_eff) || (8'(in_col) >= w_eff);
              state_d   = ST_INDEX;
            end
          endcase
        end
      end

      ST_COL_MUL: state_d = ST_COL_DIV;

      ST_COL_DIV: begin
        if (div_rsp.done) begin
          col_d   = (sx_q == '0) ? '0 : div_rsp.quot;
          state_d = ST_ROW_MUL;
        end
      end

      ST_ROW_MUL: state_d = ST_ROW_DIV;

      ST_ROW_DIV: begin
        if (div_rsp.done) begin
          row_d   = (sy_q == '0) ? '0 : div_rsp.quot;
          state_d = ST_INDEX;
        end
      end

      ST_INDEX: begin
        idx_d   = IDX_W'(idx_prod) + IDX_W'(col_q);
        state_d = ST_MEM_RD;
      end

      ST_MEM_RD: state_d = ST_MEM_USE;

      ST_MEM_USE: begin
        if (is_read_q) begin
          if (bad_rc_q || !idx_ok) begin
            status_d = STS_BAD_CELL;
          end else begin
            char_d = rd_q;
          end
        end else begin
          mem_we = idx_ok;
        end
        state_d = ST_DONE;
      end

      ST_DONE: begin
        // Hold until the output register is free.
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_d      = {6'd0, hiy_q, loy_q, hix_q, lox_q, cnt_q, char_q, status_q};
          clr_resp_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      clr_resp_q <= 1'b0;
      lox_q      <= 32'sh7FFFFFFF;
      hix_q      <= 32'sh80000000;
      loy_q      <= 32'sh7FFFFFFF;
      hiy_q      <= 32'sh80000000;
      cnt_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      clr_resp_q <= clr_resp_d;
      lox_q      <= lox_d;
      hix_q      <= hix_d;
      loy_q      <= loy_d;
      hiy_q      <= hiy_d;
      cnt_q      <= cnt_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    char_q    <= char_d;
    curve_q   <= curve_d;
    is_read_q <= is_read_d;
    bad_rc_q  <= bad_rc_d;
    sx_q      <= sx_d;
    dx_q      <= dx_d;
    sy_q      <= sy_d;
    dy_q      <= dy_d;
    row_q     <= row_d;
    col_q     <= col_d;
    idx_q     <= idx_d;
    out_q     <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `CRP_ASSERT_IMP(a_div_done_in_div, div_rsp.done,
    state_q == ST_COL_DIV || state_q == ST_ROW_DIV, "divider done outside a divide step")
  `CRP_ASSERT_NXT(a_done_loads_out, state_q == ST_DONE && (!out_vld_q || m_axis_tready),
    m_axis_tvalid && state_q == ST_IDLE, "result not loaded from done state")
  `CRP_ASSERT_NXT(a_start_clears, accept && in_req == REQ_START && !too_big,
    state_q == ST_CLEAR && cnt_q == '0, "start did not begin the grid sweep")

endmodule

### tb/plot_result_checker.sv
// ----------------------------------------------------------------------------
// plot_result_checker
// Watches the config port and both streams and predicts every plot result.
// It keeps its own copy of the page, the bounds and the grid, and compares
// each result with the oldest expected one, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plot_result_checker
  import crp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel_i,
  input  logic         penable_i,
  input  logic         pwrite_i,
  input  logic [4:0]   paddr_i,
  input  logic [31:0]  pwdata_i,
  input  logic         pready_i,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [87:0]  s_tdata_i,
  input  logic [1:0]   s_tuser_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [159:0] m_tdata_i,
  output int           fail_count_o,
  output int           pending_o
);

  logic [7:0]         page_w, page_l;
  logic [3:0]         lim_mask;
  logic signed [31:0] lim_xl, lim_xh, lim_yl, lim_yh;
  logic signed [31:0] lo_x, hi_x, lo_y, hi_y;
  logic [15:0]        pts;
  logic [7:0]         grid [CELL_COUNT_DEF];
  logic [159:0]       expected_results [$];
  int                 mismatches;

  assign pending_o = expected_results.size();

  function automatic longint unsigned axis_pos(longint unsigned scale,
                                               longint unsigned off,
                                               longint unsigned span);
    if (span == 0) return 0;
    return (scale * off * 2 + span) / (span * 2);
  endfunction

  // Apply one request to the shadow state and return its result word.
  function automatic logic [159:0] plot_predict(logic [1:0] req, logic [87:0] d);
    logic [2:0]         curve;
    logic signed [31:0] x, y;
    logic [6:0]         rrow, rcol;
    longint unsigned    w, l, sx, sy, dx, dy, row, col, idx, cells;
    logic [1:0]         sts;
    logic [7:0]         ch, c;
    curve = d[2:0];
    x     = d[34:3];
    y     = d[66:35];
    rrow  = d[73:67];
    rcol  = d[80:74];
    w     = (page_w != 0) ? page_w : 1;
    l     = (page_l != 0) ? page_l : 1;
    sts   = STS_OK;
    ch    = 8'd0;
    case (req)
      REQ_START: begin
        cells = longint'(page_w) * longint'(page_l);
        if (cells > MAX_PAGE_CHARS || cells > CELL_COUNT_DEF) begin
          sts = STS_TOO_BIG;
        end else begin
          foreach (grid[i]) grid[i] = CHR_SPACE;
          lo_x = lim_mask[0] ? lim_xl : 32'sh7FFFFFFF;
          hi_x = lim_mask[1] ? lim_xh : 32'sh80000000;
          lo_y = lim_mask[2] ? lim_yl : 32'sh7FFFFFFF;
          hi_y = lim_mask[3] ? lim_yh : 32'sh80000000;
          pts  = 16'd0;
        end
      end
      REQ_BOUND: begin
        if (!((curve >= NUM_CURVES_DEF) || (lim_mask[0] && x < lo_x) ||
              (lim_mask[1] && x > hi_x) || (lim_mask[2] && y < lo_y) ||
              (lim_mask[3] && y > hi_y))) begin
          if (x < lo_x) lo_x = x;
          if (x > hi_x) hi_x = x;
          if (y < lo_y) lo_y = y;
          if (y > hi_y) hi_y = y;
          if (pts != 16'hFFFF) pts = pts + 16'd1;
        end
      end
      REQ_PLOT: begin
        if (pts == 0) begin
          sts = STS_NO_DATA;
        end else if (curve < NUM_CURVES_DEF && x >= lo_x && x <= hi_x &&
                     y >= lo_y && y <= hi_y) begin
          sx  = longint'(hi_x) - longint'(lo_x);
          sy  = longint'(hi_y) - longint'(lo_y);
          dx  = longint'(x) - longint'(lo_x);
          dy  = longint'(y) - longint'(lo_y);
          row = (sy == 0) ? 0 : axis_pos(l - 1, sy - dy, sy);
          col = axis_pos(w - 1, dx, sx);
          idx = row * w + col;
          if (idx < CELL_COUNT_DEF) begin
            c = grid[idx];
            if (c == CHR_SPACE)                  grid[idx] = CHR_A + 8'(curve);
            else if (c > CHR_ONE && c < CHR_NINE) grid[idx] = c + 8'd1;
            else if (c == CHR_NINE)              grid[idx] = CHR_STAR;
            else if (c != CHR_STAR)              grid[idx] = CHR_TWO;
          end
        end
      end
      default: begin
        idx = longint'(rrow) * w + longint'(rcol);
        if (rrow >= l || rcol >= w || idx >= CELL_COUNT_DEF) sts = STS_BAD_CELL;
        else ch = grid[idx];
      end
    endcase
    return {6'd0, hi_y, lo_y, hi_x, lo_x, pts, ch, sts};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [159:0] exp_w;
    if (!rst_ni) begin
      page_w   <= 8'd80;
      page_l   <= 8'd24;
      lim_mask <= 4'd0;
      lim_xl   <= '0;
      lim_xh   <= '0;
      lim_yl   <= '0;
      lim_yh   <= '0;
      lo_x = 32'sh7FFFFFFF;
      hi_x = 32'sh80000000;
      lo_y = 32'sh7FFFFFFF;
      hi_y = 32'sh80000000;
      pts  = 16'd0;
      foreach (grid[i]) grid[i] = CHR_SPACE;
      fail_count_o <= 0;
      mismatches = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[4:2])
          REG_PAGE_WIDTH:  page_w   <= pwdata_i[7:0];
          REG_PAGE_LENGTH: page_l   <= pwdata_i[7:0];
          REG_LIMIT_MASK:  lim_mask <= pwdata_i[3:0];
          REG_X_LOW:       lim_xl   <= pwdata_i;
          REG_X_HIGH:      lim_xh   <= pwdata_i;
          REG_Y_LOW:       lim_yl   <= pwdata_i;
          REG_Y_HIGH:      lim_yh   <= pwdata_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i)
        expected_results.push_back(plot_predict(s_tuser_i, s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        if (expected_results.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("unexpected result %h", m_tdata_i);
        end else begin
          exp_w = expected_results.pop_front();
          if (exp_w[1:0] !== m_tdata_i[1:0] || exp_w[9:2] !== m_tdata_i[9:2] ||
              exp_w[25:10] !== m_tdata_i[25:10] ||
              exp_w[57:26] !== m_tdata_i[57:26] ||
              exp_w[89:58] !== m_tdata_i[89:58] ||
              exp_w[121:90] !== m_tdata_i[121:90] ||
              exp_w[153:122] !== m_tdata_i[153:122] ||
              exp_w[159:154] !== m_tdata_i[159:154]) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) begin
              $write("mismatch sts %0d/%0d chr %h/%h cnt %0d/%0d ",
                     exp_w[1:0], m_tdata_i[1:0], exp_w[9:2], m_tdata_i[9:2],
                     exp_w[25:10], m_tdata_i[25:10]);
              $display("xl %h/%h xh %h/%h yl %h/%h yh %h/%h",
                       exp_w[57:26], m_tdata_i[57:26],
                       exp_w[89:58], m_tdata_i[89:58], exp_w[121:90], m_tdata_i[121:90],
                       exp_w[153:122], m_tdata_i[153:122]);
            end
          end
        end
      end
      fail_count_o <= mismatches;
    end
  end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the character plot rasterizer.
// Drives directed and random requests over several page and limit settings,
// with random idling on both streams; the checker does the comparing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import crp_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [87:0]  s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;

  int fails, pending;
  int send_idle_pct = 0;   // chance per cycle that the sender stays quiet
  int recv_stall_pct = 0;  // chance per cycle that the receiver stalls
  bit hold_off_req = 0;    // ask the receiver for one long hold-off
  bit hold_done = 0;       // the long hold-off has been taken

  // Current page and point cloud, used to aim random requests.
  int unsigned cur_w = 80, cur_l = 24;
  int          ctr_x, ctr_y, spread;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  char_plot_rasterizer DUT (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  plot_result_checker chk (
    .clk_i, .rst_ni,
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tuser_i(s_axis_tuser),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_tdata_i(m_axis_tdata),
    .fail_count_o(fails), .pending_o(pending)
  );

  // Receiver: random stalls, plus one long hold-off on request so the block
  // backs up into its input while the sender keeps offering.
  always @(posedge clk_i) begin
    int hold_cnt;
    if (hold_off_req && !hold_done) begin
      hold_done = 1;
      hold_cnt  = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Write one register: setup cycle, then access cycle.
  task automatic reg_write(crp_reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offer one request and hold it until the block takes it.
  task automatic send_req(crp_req_e req, logic [2:0] curve, logic [31:0] x,
                          logic [31:0] y, logic [6:0] row, logic [6:0] col);
    bit ok;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {7'd0, col, row, y, x, curve};
    do begin
      @(negedge clk_i);
      ok = s_axis_tready;
      @(posedge clk_i);
    end while (!ok);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_coord(int ctr);
    if ($urandom_range(19) == 0) return $urandom;
    return ctr + $signed($urandom_range(2 * spread)) - spread;
  endfunction

  // Mostly well-formed traffic: a start, then bound points, plots and reads
  // mixed at random, with a few more starts, out-of-range reads and wild points.
  task automatic random_traffic(int n);
    int unsigned r;
    logic [6:0]  row, col;
    send_req(REQ_START, 3'd0, $urandom, $urandom, 7'd0, 7'd0);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 3) begin
        send_req(REQ_START, 3'($urandom), $urandom, $urandom, 7'($urandom),
                 7'($urandom));
      end else if (r < 33) begin
        send_req(REQ_BOUND, 3'($urandom), pick_coord(ctr_x), pick_coord(ctr_y),
                 7'($urandom), 7'($urandom));
      end else if (r < 73) begin
        send_req(REQ_PLOT, 3'($urandom), pick_coord(ctr_x), pick_coord(ctr_y),
                 7'($urandom), 7'($urandom));
      end else begin
        row = ($urandom_range(4) == 0) ? 7'($urandom) : 7'($urandom_range(cur_l - 1));
        col = ($urandom_range(4) == 0) ? 7'($urandom) : 7'($urandom_range(cur_w - 1));
        send_req(REQ_READ, 3'($urandom), $urandom, $urandom, row, col);
      end
    end
  endtask

  task automatic set_page(logic [7:0] w, logic [7:0] l, logic [3:0] mask);
    reg_write(REG_PAGE_WIDTH, 32'(w));
    reg_write(REG_PAGE_LENGTH, 32'(l));
    reg_write(REG_LIMIT_MASK, 32'(mask));
    cur_w = (w == 0) ? 1 : ((w > 128) ? 128 : w);
    cur_l = (l == 0) ? 1 : ((l > 128) ? 128 : l);
  endtask

  initial begin
    logic [7:0] pw, pl;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: read and plot before any data, then extremes and a cell
    // hit until it saturates at the star.
    send_req(REQ_READ, 3'd0, 32'd0, 32'd0, 7'd0, 7'd0);
    send_req(REQ_PLOT, 3'd1, 32'd0, 32'd0, 7'd0, 7'd0);
    send_req(REQ_START, 3'd0, 32'd0, 32'd0, 7'd0, 7'd0);
    send_req(REQ_BOUND, 3'd0, 32'h80000000, 32'h80000000, 7'd0, 7'd0);
    send_req(REQ_BOUND, 3'd7, 32'h7FFFFFFF, 32'h7FFFFFFF, 7'd127, 7'd127);
    send_req(REQ_PLOT, 3'd7, 32'h80000000, 32'h7FFFFFFF, 7'd0, 7'd0);
    send_req(REQ_PLOT, 3'd2, 32'h7FFFFFFF, 32'h80000000, 7'd0, 7'd0);
    for (int i = 0; i < 11; i++)
      send_req(REQ_PLOT, 3'(i), 32'd0, 32'd0, 7'd0, 7'd0);
    send_req(REQ_READ, 3'd0, 32'd0, 32'd0, 7'd12, 7'd40);
    send_req(REQ_READ, 3'd0, 32'd0, 32'd0, 7'd0, 7'd0);
    send_req(REQ_READ, 3'd0, 32'd0, 32'd0, 7'd23, 7'd79);
    send_req(REQ_READ, 3'd0, 32'd0, 32'd0, 7'd24, 7'd0);
    send_req(REQ_READ, 3'd0, 32'd0, 32'd0, 7'd0, 7'd80);
    send_req(REQ_READ, 3'd0, 32'd0, 32'd0, 7'd127, 7'd127);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin pw = 8'd1;   pl = 8'd1;   end
        1: begin pw = 8'd128; pl = 8'd64;  end
        2: begin pw = 8'd255; pl = 8'd32;  end
        3: begin pw = 8'd0;   pl = 8'd0;   end
        4: begin pw = 8'd128; pl = 8'd128; end  // too big: starts refused
        default: begin
          pw = 8'($urandom_range(1, 128));
          pl = 8'($urandom_range(1, 8192 / pw > 128 ? 128 : 8192 / pw));
        end
      endcase
      set_page(pw, pl, (ph == 0) ? 4'd0 : (ph == 3) ? 4'hF : 4'($urandom));
      ctr_x  = $urandom_range(1 << 20) - (1 << 19);
      ctr_y  = $urandom_range(1 << 20) - (1 << 19);
      case ($urandom_range(3))
        0: spread = 0;
        1: spread = 4;
        2: spread = 1 << 17;
        default: spread = $urandom_range(1 << 28);
      endcase
      if (ph == 2) begin
        reg_write(REG_X_LOW, 32'h80000000);
        reg_write(REG_X_HIGH, 32'h7FFFFFFF);
        reg_write(REG_Y_LOW, 32'h80000000);
        reg_write(REG_Y_HIGH, 32'h7FFFFFFF);
      end else begin
        reg_write(REG_X_LOW, ctr_x - $urandom_range(spread));
        reg_write(REG_X_HIGH, ctr_x + $urandom_range(spread));
        reg_write(REG_Y_LOW, ctr_y - $urandom_range(spread));
        reg_write(REG_Y_HIGH, ctr_y + $urandom_range(spread));
      end
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      if (ph == 1) hold_off_req = 1;
      random_traffic(190);
      drain();
    end

    // Close with a short burst of bound points and one plot.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_page(8'd40, 8'd20, 4'd0);
    send_req(REQ_START, 3'd0, 32'd0, 32'd0, 7'd0, 7'd0);
    for (int i = 0; i < 50; i++)
      send_req(REQ_BOUND, 3'($urandom), $urandom, $urandom, 7'd0, 7'd0);
    send_req(REQ_PLOT, 3'd3, 32'd0, 32'd0, 7'd0, 7'd0);
    drain();

    if (fails == 0 && pending == 0) begin
      $display("char_plot_rasterizer verification clean");
    end else begin
      $display("char_plot_rasterizer verification failed");
    end
    $finish;
  end

  initial begin
    #1s;
    $display("char_plot_rasterizer verification failed");
    $finish;
  end

endmodule
